/* sv/mcr_pkg.sv */
// shared types and constants for the midpoint circle rasterizer
// no dependencies; used by every module of the block through scoped names
package mcr_pkg;

  // coordinate widths
  localparam int COORD_WIDTH = 11;
  localparam int OFF_WIDTH   = COORD_WIDTH + 1;
  localparam int DEC_WIDTH   = COORD_WIDTH + 3;
  localparam int PIX_WIDTH   = COORD_WIDTH + 2;

  // step queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // request opcodes
  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  // pixel order within one step
  typedef enum logic [2:0] {
    OCT_PX_PY = 3'd0,
    OCT_PY_PX = 3'd1,
    OCT_PY_NX = 3'd2,
    OCT_PX_NY = 3'd3,
    OCT_NX_NY = 3'd4,
    OCT_NY_NX = 3'd5,
    OCT_NY_PX = 3'd6,
    OCT_NX_PY = 3'd7
  } octant_t;

  // one step worth of work handed from front to back
  typedef struct packed {
    logic [COORD_WIDTH-1:0] cx;
    logic [COORD_WIDTH-1:0] cy;
    logic [OFF_WIDTH-1:0]   x;
    logic [OFF_WIDTH-1:0]   y;
    logic                   done;
  } step_t;

endpackage

/* sv/mcr_front.sv */
// front end: accepts requests, keeps the circle state, issues step records
// depends on mcr_pkg
module mcr_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           op,
  input  logic [mcr_pkg::COORD_WIDTH-1:0] center_x,
  input  logic [mcr_pkg::COORD_WIDTH-1:0] center_y,
  input  logic [mcr_pkg::COORD_WIDTH-1:0] radius,
  output logic                           push_valid,
  input  logic                           push_ready,
  output mcr_pkg::step_t                 push_data
);

  logic [mcr_pkg::COORD_WIDTH-1:0]      centre_x_reg;
  logic [mcr_pkg::COORD_WIDTH-1:0]      centre_y_reg;
  logic [mcr_pkg::OFF_WIDTH-1:0]        offset_x;
  logic [mcr_pkg::OFF_WIDTH-1:0]        offset_y;
  logic signed [mcr_pkg::DEC_WIDTH-1:0] decision;
  logic                                 active;

  logic [mcr_pkg::OFF_WIDTH-1:0]        offset_x_next;
  logic [mcr_pkg::OFF_WIDTH-1:0]        offset_y_next;
  logic signed [mcr_pkg::DEC_WIDTH-1:0] decision_next;
  logic                                 active_next;
  logic signed [mcr_pkg::DEC_WIDTH-1:0] x_s;
  logic signed [mcr_pkg::DEC_WIDTH-1:0] y_s;
  logic signed [mcr_pkg::DEC_WIDTH-1:0] r_s;
  logic                                 accept;

  // requests wait only on room in the step queue
  assign in_ready = push_ready;
  assign accept   = in_valid && in_ready;

  // next point of the octant walk
  always_comb begin
    offset_x_next = offset_x + mcr_pkg::OFF_WIDTH'(1);
    offset_y_next = (decision > 0) ? offset_y - mcr_pkg::OFF_WIDTH'(1) : offset_y;
    x_s = signed'(mcr_pkg::DEC_WIDTH'(offset_x_next));
    y_s = signed'(mcr_pkg::DEC_WIDTH'(offset_y_next));
    if (decision > 0) begin
      decision_next = decision + ((x_s - y_s) <<< 1) + mcr_pkg::DEC_WIDTH'(1);
    end else begin
      decision_next = decision + (x_s <<< 1) + mcr_pkg::DEC_WIDTH'(1);
    end
    active_next = offset_x_next < offset_y_next;
    r_s = signed'(mcr_pkg::DEC_WIDTH'(radius));
  end

  // step record for the back end
  assign push_valid     = accept && (op == mcr_pkg::OP_STEP) && active;
  assign push_data.cx   = centre_x_reg;
  assign push_data.cy   = centre_y_reg;
  assign push_data.x    = offset_x;
  assign push_data.y    = offset_y;
  assign push_data.done = !active_next;

  // circle state
  always_ff @(posedge clk) begin
    if (rst) begin
      centre_x_reg <= '0;
      centre_y_reg <= '0;
      offset_x     <= '0;
      offset_y     <= '0;
      decision     <= '0;
      active       <= 1'b0;
    end else if (accept) begin
      if (op == mcr_pkg::OP_START) begin
        centre_x_reg <= center_x;
        centre_y_reg <= center_y;
        offset_x     <= '0;
        offset_y     <= mcr_pkg::OFF_WIDTH'(radius);
        decision     <= mcr_pkg::DEC_WIDTH'(1) - r_s;
        active       <= radius != '0;
      end else if (active) begin
        offset_x <= offset_x_next;
        offset_y <= offset_y_next;
        decision <= decision_next;
        active   <= active_next;
      end
    end
  end

endmodule

/* sv/mcr_queue.sv */
// short fifo of step records between front and back
// depends on mcr_pkg
module mcr_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  mcr_pkg::step_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output mcr_pkg::step_t pop_data
);

  mcr_pkg::step_t                entries [mcr_pkg::QUEUE_DEPTH];
  logic [mcr_pkg::QUEUE_AW-1:0]  wptr;
  logic [mcr_pkg::QUEUE_AW-1:0]  rptr;
  logic [mcr_pkg::QUEUE_AW:0]    count;
  logic                          do_push;
  logic                          do_pop;

  assign push_ready = count != (mcr_pkg::QUEUE_AW + 1)'(mcr_pkg::QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_data   = entries[rptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) wptr <= wptr + mcr_pkg::QUEUE_AW'(1);
      if (do_pop)  rptr <= rptr + mcr_pkg::QUEUE_AW'(1);
      if (do_push && !do_pop) begin
        count <= count + (mcr_pkg::QUEUE_AW + 1)'(1);
      end else if (do_pop && !do_push) begin
        count <= count - (mcr_pkg::QUEUE_AW + 1)'(1);
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) entries[wptr] <= push_data;
  end

endmodule

/* sv/mcr_back.sv */
// back end: expands one step record into eight pixels, one per cycle unless out_ready stalls
// depends on mcr_pkg
module mcr_back (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                pop_valid,
  output logic                                pop_ready,
  input  mcr_pkg::step_t                      pop_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [mcr_pkg::PIX_WIDTH-1:0] pixel_x,
  output logic signed [mcr_pkg::PIX_WIDTH-1:0] pixel_y,
  output logic                                last_of_step,
  output logic                                circle_done
);

  mcr_pkg::octant_t                     octant;
  logic                                 advance;
  logic signed [mcr_pkg::PIX_WIDTH-1:0] cx_s;
  logic signed [mcr_pkg::PIX_WIDTH-1:0] cy_s;
  logic signed [mcr_pkg::PIX_WIDTH-1:0] x_s;
  logic signed [mcr_pkg::PIX_WIDTH-1:0] y_s;
  logic signed [mcr_pkg::PIX_WIDTH-1:0] dx;
  logic signed [mcr_pkg::PIX_WIDTH-1:0] dy;

  // move a pixel into the output register when it is empty or being taken
  assign advance   = pop_valid && (!out_valid || out_ready);
  assign pop_ready = advance && (octant == mcr_pkg::OCT_NX_PY);

  // symmetric offsets for the current octant
  always_comb begin
    cx_s = signed'(mcr_pkg::PIX_WIDTH'(pop_data.cx));
    cy_s = signed'(mcr_pkg::PIX_WIDTH'(pop_data.cy));
    x_s  = signed'(mcr_pkg::PIX_WIDTH'(pop_data.x));
    y_s  = signed'(mcr_pkg::PIX_WIDTH'(pop_data.y));
    unique case (octant)
      mcr_pkg::OCT_PX_PY: begin dx = x_s;  dy = y_s;  end
      mcr_pkg::OCT_PY_PX: begin dx = y_s;  dy = x_s;  end
      mcr_pkg::OCT_PY_NX: begin dx = y_s;  dy = -x_s; end
      mcr_pkg::OCT_PX_NY: begin dx = x_s;  dy = -y_s; end
      mcr_pkg::OCT_NX_NY: begin dx = -x_s; dy = -y_s; end
      mcr_pkg::OCT_NY_NX: begin dx = -y_s; dy = -x_s; end
      mcr_pkg::OCT_NY_PX: begin dx = -y_s; dy = x_s;  end
      mcr_pkg::OCT_NX_PY: begin dx = -x_s; dy = y_s;  end
      default:            begin dx = x_s;  dy = y_s;  end
    endcase
  end

  // octant counter and valid of the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      octant    <= mcr_pkg::OCT_PX_PY;
      out_valid <= 1'b0;
    end else if (advance) begin
      octant    <= mcr_pkg::octant_t'(octant + 3'd1);
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (advance) begin
      pixel_x      <= cx_s + dx;
      pixel_y      <= cy_s + dy;
      last_of_step <= octant == mcr_pkg::OCT_NX_PY;
      circle_done  <= pop_data.done;
    end
  end

endmodule

/* sv/midpoint_circle_rasterizer.sv */
// Midpoint circle rasterizer with eight-way symmetry. A start request (op 0)
// loads centre and radius and returns nothing; each step request (op 1) on a
// running circle returns eight pixels in octant order, the eighth flagged with
// last_of_step, all eight flagged with circle_done on the step that ends the
// circle. A step while idle is accepted and returns nothing. Requests are
// taken one per cycle while the two-entry step queue has room; each step
// then holds the pixel unit for its eight pixels, one pixel per cycle unless
// out_ready stalls the single output port. A step record passes through the
// step queue and then the output register of the back end before its first pixel.
// top level: front end, step queue, back end; depends on mcr_pkg
module midpoint_circle_rasterizer (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                op,
  input  logic [mcr_pkg::COORD_WIDTH-1:0]     center_x,
  input  logic [mcr_pkg::COORD_WIDTH-1:0]     center_y,
  input  logic [mcr_pkg::COORD_WIDTH-1:0]     radius,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [mcr_pkg::PIX_WIDTH-1:0] pixel_x,
  output logic signed [mcr_pkg::PIX_WIDTH-1:0] pixel_y,
  output logic                                last_of_step,
  output logic                                circle_done
);

  logic           push_valid;
  logic           push_ready;
  mcr_pkg::step_t push_data;
  logic           pop_valid;
  logic           pop_ready;
  mcr_pkg::step_t pop_data;

  // request decode and circle state
  mcr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .op         (op),
    .center_x   (center_x),
    .center_y   (center_y),
    .radius     (radius),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // decoupling queue
  mcr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // pixel expansion
  mcr_back u_back (
    .clk          (clk),
    .rst          (rst),
    .pop_valid    (pop_valid),
    .pop_ready    (pop_ready),
    .pop_data     (pop_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .last_of_step (last_of_step),
    .circle_done  (circle_done)
  );

endmodule

/* sv/mcr_checker.sv */
// port-level checks for the midpoint circle rasterizer, bound to the top level
// depends on mcr_pkg
module mcr_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [mcr_pkg::PIX_WIDTH-1:0] pixel_x,
  input logic signed [mcr_pkg::PIX_WIDTH-1:0] pixel_y,
  input logic                                last_of_step,
  input logic                                circle_done
);

  // stalled pixel holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pixel_x) && $stable(pixel_y))
    else $error("stalled pixel changed");

  // pixels of one step follow without a gap and share the done flag
  a_step_burst: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_of_step |=>
      out_valid && (circle_done == $past(circle_done)))
    else $error("step burst broken");

  // a new step never opens with the last flag
  a_last_once: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && last_of_step |=> !(out_valid && last_of_step))
    else $error("last flag repeated");

  // requests are held off only while pixels are pending
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |-> out_valid)
    else $error("input stalled with no output pending");

  // nothing comes out right after reset
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind midpoint_circle_rasterizer mcr_checker u_mcr_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .pixel_x      (pixel_x),
  .pixel_y      (pixel_y),
  .last_of_step (last_of_step),
  .circle_done  (circle_done)
);
